// ===== design/separable_3d_window_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the separable 3-D window filter
// Shared assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_3D_WINDOW_FILTER_ASSERT_SVH
`define SEPARABLE_3D_WINDOW_FILTER_ASSERT_SVH

// check a property outside reset
`define SF3_CHECK(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("sf3 check failed");

// check a property in every cycle, reset included
`define SF3_CHECK_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("sf3 check failed");

`endif

// ===== design/sf3_pkg.sv =====
// ----------------------------------------------------------------------------
// sf3_pkg
// Types and constants shared by the separable 3-D window filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sf3_pkg;

   localparam int COEF_W   = 18;
   localparam int SAMPLE_W = 16;
   localparam int FILT_W   = 24;
   localparam int POS_W    = 6;

   localparam logic signed [FILT_W-1:0] FILT_MAX = 24'sh7FFFFF;
   localparam logic signed [FILT_W-1:0] FILT_MIN = -24'sh800000;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   // coefficient tables
   localparam logic [1:0] AXIS_TIME   = 2'd0;
   localparam logic [1:0] AXIS_HEIGHT = 2'd1;
   localparam logic [1:0] AXIS_WIDTH  = 2'd2;

   // register indexes
   localparam logic [2:0] REG_PLANE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_PLANE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_TAPS_TIME    = 3'd2;
   localparam logic [2:0] REG_TAPS_HEIGHT  = 3'd3;
   localparam logic [2:0] REG_TAPS_WIDTH   = 3'd4;

   typedef struct packed {
      logic                     we;
      logic [4:0]               idx;
      logic signed [COEF_W-1:0] value;
   } coef_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_PUSH
   } sf3_state_type;

endpackage

`default_nettype wire

// ===== design/separable_3d_window_filter.sv =====
// ----------------------------------------------------------------------------
// separable_3d_window_filter
// Valid-mode separable 3-D FIR over a ring of recent sample planes.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item per handshake. tuser = 1 loads a coefficient
//   (axis, index, value), tuser = 0 carries a sample in raster order.
//   rsp channel: one filtered result for each sample that completes a
//   taps_time x taps_height x taps_width window; tlast marks the last
//   output of a plane.
//   csr port: APB registers plane_width, plane_height, taps_time,
//   taps_height, taps_width at byte addresses 0, 4, 8, 12, 16.
// Timing:
//   A coefficient item or a sample without output leaves the input ready.
//   A sample with output holds off further items until its result is
//   loaded: the window is read from the plane memory one word per cycle
//   and runs through a chain of three multiply-accumulate cells (width,
//   height, time); the single read port sets that pace.
// Reset clears the stream position and registers; the plane memory and
// tap tables are not cleared. A stalled receiver holds the result in the
// output register; the next item is still taken, and a further result
// waits until that register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_3d_window_filter
   import sf3_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_TAPS   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // sample and coefficient items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] axis, [6:2] coef_index, [24:7] coef_value, [40:25] sample
   input  wire logic [47:0] req_tdata,
   // [0] kind
   input  wire logic        req_tuser,
   // results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [23:0] filtered, [29:24] out_row, [35:30] out_col
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tlast,
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int SW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int PWW   = $clog2(MAX_WIDTH + 1);
   localparam int PHW   = $clog2(MAX_HEIGHT + 1);
   localparam int TW    = $clog2(MAX_TAPS + 1);
   localparam int AW    = SW + RW + CW;
   localparam int XW    = 16;
   localparam int W_OUT = SAMPLE_W + COEF_W + TW - 15;
   localparam int H_OUT = W_OUT + COEF_W + TW - 15;
   localparam int T_OUT = H_OUT + COEF_W + TW - 15;

   // input fields
   logic                       kind;
   logic [1:0]                 axis;
   logic [4:0]                 coef_index;
   logic signed [COEF_W-1:0]   coef_value;
   logic signed [SAMPLE_W-1:0] sample;

   assign kind       = req_tuser;
   assign axis       = req_tdata[1:0];
   assign coef_index = req_tdata[6:2];
   assign coef_value = req_tdata[24:7];
   assign sample     = req_tdata[40:25];

   // registers
   logic [PWW-1:0] pw_ff, pw_in;
   logic [PHW-1:0] ph_ff, ph_in;
   logic [TW-1:0]  tt_ff, tt_in, th_ff, th_in, tw_ff, tw_in;
   logic           cfg_wr, restart;
   logic [6:0]     v7;
   logic [5:0]     v6;
   logic [TW-1:0]  taps_val;

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // mask and clamp a register write
   always_comb begin
      v7      = csr_pwdata[6:0];
      v6      = csr_pwdata[5:0];
      pw_in   = pw_ff;
      ph_in   = ph_ff;
      tt_in   = tt_ff;
      th_in   = th_ff;
      tw_in   = tw_ff;
      restart = 1'b0;
      if (v6 == 6'd0) begin
         taps_val = TW'(1);
      end else if (32'(v6) > MAX_TAPS) begin
         taps_val = TW'(MAX_TAPS);
      end else begin
         taps_val = TW'(v6);
      end
      if (cfg_wr) begin
         unique case (csr_paddr[4:2])
            REG_PLANE_WIDTH: begin
               restart = 1'b1;
               if (v7 == 7'd0) begin
                  pw_in = PWW'(1);
               end else if (32'(v7) > MAX_WIDTH) begin
                  pw_in = PWW'(MAX_WIDTH);
               end else begin
                  pw_in = PWW'(v7);
               end
            end
            REG_PLANE_HEIGHT: begin
               restart = 1'b1;
               if (v7 == 7'd0) begin
                  ph_in = PHW'(1);
               end else if (32'(v7) > MAX_HEIGHT) begin
                  ph_in = PHW'(MAX_HEIGHT);
               end else begin
                  ph_in = PHW'(v7);
               end
            end
            REG_TAPS_TIME:   tt_in = taps_val;
            REG_TAPS_HEIGHT: th_in = taps_val;
            REG_TAPS_WIDTH:  tw_in = taps_val;
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_paddr[4:2])
         REG_PLANE_WIDTH:  csr_prdata = 32'(pw_ff);
         REG_PLANE_HEIGHT: csr_prdata = 32'(ph_ff);
         REG_TAPS_TIME:    csr_prdata = 32'(tt_ff);
         REG_TAPS_HEIGHT:  csr_prdata = 32'(th_ff);
         REG_TAPS_WIDTH:   csr_prdata = 32'(tw_ff);
         default:          csr_prdata = 32'd0;
      endcase
   end

   // stream position and sequencer
   sf3_state_type state_ff, state_in;
   logic [SW-1:0] newest_ff, newest_in, held_ff, held_in;
   logic [RW-1:0] row_ff, row_in, r0_ff, r0_in;
   logic [CW-1:0] col_ff, col_in, c0_ff, c0_in;
   logic          done_ff, done_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [TW-1:0] tc_ff, tc_in, ty_ff, ty_in, tx_ff, tx_in;
   logic          accept, smp_acc, emit, rd_issue, rd_valid_ff, load_rsp;
   logic [XW-1:0] start_slot;
   logic [AW-1:0] waddr, raddr;
   logic [SAMPLE_W-1:0] rdata;
   logic signed [FILT_W-1:0] res_ff, res_in;
   logic signed [FILT_W-1:0] sat;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [39:0]   rsp_tdata_ff;
   logic          rsp_tlast_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign smp_acc    = accept && (kind == KIND_SAMPLE);
   assign rd_issue   = (state_ff == ST_RUN);
   assign load_rsp   = (state_ff == ST_PUSH) && (!rsp_tvalid_ff || rsp_tready);

   assign waddr = {newest_ff, row_ff, col_ff};
   assign raddr = {slot_ff, RW'(XW'(r0_ff) + XW'(ty_ff)), CW'(XW'(c0_ff) + XW'(tx_ff))};

   assign emit = (XW'(held_ff) + XW'(1) >= XW'(tt_ff))
              && (XW'(row_ff) + XW'(1) >= XW'(th_ff))
              && (XW'(col_ff) + XW'(1) >= XW'(tw_ff));

   // oldest ring slot of the window
   always_comb begin
      start_slot = XW'(newest_ff) + XW'(MAX_TAPS) + XW'(1) - XW'(tt_ff);
      if (start_slot >= XW'(MAX_TAPS)) begin
         start_slot = start_slot - XW'(MAX_TAPS);
      end
   end

   logic          t_valid;
   logic signed [T_OUT-1:0] t_data;

   always_comb begin
      state_in  = state_ff;
      newest_in = newest_ff;
      held_in   = held_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      r0_in     = r0_ff;
      c0_in     = c0_ff;
      done_in   = done_ff;
      slot_in   = slot_ff;
      tc_in     = tc_ff;
      ty_in     = ty_ff;
      tx_in     = tx_ff;
      res_in    = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (smp_acc) begin
               // start the window walk
               if (emit) begin
                  state_in = ST_RUN;
                  r0_in    = RW'(XW'(row_ff) + XW'(1) - XW'(th_ff));
                  c0_in    = CW'(XW'(col_ff) + XW'(1) - XW'(tw_ff));
                  done_in  = (XW'(row_ff) + XW'(1) == XW'(ph_ff))
                          && (XW'(col_ff) + XW'(1) == XW'(pw_ff));
                  slot_in  = SW'(start_slot);
                  tc_in    = '0;
                  ty_in    = '0;
                  tx_in    = '0;
               end
               // advance the raster position
               if (XW'(col_ff) + XW'(1) >= XW'(pw_ff)) begin
                  col_in = '0;
                  if (XW'(row_ff) + XW'(1) >= XW'(ph_ff)) begin
                     row_in    = '0;
                     newest_in = (XW'(newest_ff) == XW'(MAX_TAPS - 1))
                              ? '0 : newest_ff + SW'(1);
                     if (XW'(held_ff) < XW'(MAX_TAPS - 1)) begin
                        held_in = held_ff + SW'(1);
                     end
                  end else begin
                     row_in = row_ff + RW'(1);
                  end
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
         end
         ST_RUN: begin
            // step column, then row, then plane
            if (tx_ff == tw_ff - TW'(1)) begin
               tx_in = '0;
               if (ty_ff == th_ff - TW'(1)) begin
                  ty_in   = '0;
                  tc_in   = tc_ff + TW'(1);
                  slot_in = (XW'(slot_ff) == XW'(MAX_TAPS - 1))
                         ? '0 : slot_ff + SW'(1);
                  if (tc_ff == tt_ff - TW'(1)) begin
                     state_in = ST_DRAIN;
                  end
               end else begin
                  ty_in = ty_ff + TW'(1);
               end
            end else begin
               tx_in = tx_ff + TW'(1);
            end
         end
         ST_DRAIN: begin
            if (t_valid) begin
               res_in   = sat;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (restart) begin
         newest_in = '0;
         held_in   = '0;
         row_in    = '0;
         col_in    = '0;
      end
   end

   // saturate the final sum
   always_comb begin
      if (t_data > T_OUT'(FILT_MAX)) begin
         sat = FILT_MAX;
      end else if (t_data < T_OUT'(FILT_MIN)) begin
         sat = FILT_MIN;
      end else begin
         sat = t_data[FILT_W-1:0];
      end
   end

   // output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (load_rsp) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff   <= r0_in;
      c0_ff   <= c0_in;
      done_ff <= done_in;
      slot_ff <= slot_in;
      tc_ff   <= tc_in;
      ty_ff   <= ty_in;
      tx_ff   <= tx_in;
      res_ff  <= res_in;
      if (load_rsp) begin
         rsp_tdata_ff <= {4'd0, POS_W'(c0_ff), POS_W'(r0_ff), res_ff};
         rsp_tlast_ff <= done_ff;
      end
      if (reset) begin
         state_ff      <= ST_IDLE;
         pw_ff         <= PWW'((MAX_WIDTH < 64) ? MAX_WIDTH : 64);
         ph_ff         <= PHW'((MAX_HEIGHT < 64) ? MAX_HEIGHT : 64);
         tt_ff         <= TW'(1);
         th_ff         <= TW'(1);
         tw_ff         <= TW'(1);
         newest_ff     <= '0;
         held_ff       <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pw_ff         <= pw_in;
         ph_ff         <= ph_in;
         tt_ff         <= tt_in;
         th_ff         <= th_in;
         tw_ff         <= tw_in;
         newest_ff     <= newest_in;
         held_ff       <= held_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         rd_valid_ff   <= rd_issue;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // plane ring
   sf3_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (1 << AW)
   ) u_planes (
      .clock (clock),
      .we    (smp_acc),
      .waddr (waddr),
      .wdata (sample),
      .raddr (raddr),
      .rdata (rdata)
   );

   // chain of axis cells: width, height, time
   coef_wr_type wr_w, wr_h, wr_t;
   logic        w_valid, h_valid;
   logic signed [W_OUT-1:0] w_data;
   logic signed [H_OUT-1:0] h_data;

   always_comb begin
      wr_t.we    = accept && (kind == KIND_COEF) && (axis == AXIS_TIME);
      wr_t.idx   = coef_index;
      wr_t.value = coef_value;
      wr_h       = wr_t;
      wr_h.we    = accept && (kind == KIND_COEF) && (axis == AXIS_HEIGHT);
      wr_w       = wr_t;
      wr_w.we    = accept && (kind == KIND_COEF) && (axis == AXIS_WIDTH);
   end

   sf3_cell #(.IN_W(SAMPLE_W), .MAX_TAPS(MAX_TAPS)) u_cell_w (
      .clock     (clock),
      .reset     (reset),
      .taps      (tw_ff),
      .coef_wr   (wr_w),
      .in_valid  (rd_valid_ff),
      .in_data   ($signed(rdata)),
      .out_valid (w_valid),
      .out_data  (w_data)
   );

   sf3_cell #(.IN_W(W_OUT), .MAX_TAPS(MAX_TAPS)) u_cell_h (
      .clock     (clock),
      .reset     (reset),
      .taps      (th_ff),
      .coef_wr   (wr_h),
      .in_valid  (w_valid),
      .in_data   (w_data),
      .out_valid (h_valid),
      .out_data  (h_data)
   );

   sf3_cell #(.IN_W(H_OUT), .MAX_TAPS(MAX_TAPS)) u_cell_t (
      .clock     (clock),
      .reset     (reset),
      .taps      (tt_ff),
      .coef_wr   (wr_t),
      .in_valid  (h_valid),
      .in_data   (h_data),
      .out_valid (t_valid),
      .out_data  (t_data)
   );

endmodule

`default_nettype wire

// ===== design/sf3_ram.sv =====
// ----------------------------------------------------------------------------
// sf3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sf3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/sf3_cell.sv =====
// ----------------------------------------------------------------------------
// sf3_cell
// One axis of the separable sum: holds its tap table, multiplies each
// incoming term by the reversed tap, accumulates, rounds and hands the
// finished sum to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sf3_cell
   import sf3_pkg::*;
#(
   parameter int IN_W     = 16,
   parameter int MAX_TAPS = 32,
   localparam int CNT_W   = $clog2(MAX_TAPS + 1),
   localparam int OUT_W   = IN_W + COEF_W + CNT_W - 15
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [CNT_W-1:0]        taps,
   input  wire coef_wr_type             coef_wr,
   input  wire logic                    in_valid,
   input  wire logic signed [IN_W-1:0]  in_data,
   output logic                         out_valid,
   output logic signed [OUT_W-1:0]      out_data
);

   localparam int IDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int PROD_W = IN_W + COEF_W;
   localparam int ACC_W  = PROD_W + CNT_W;

   logic signed [COEF_W-1:0] coef_ff [MAX_TAPS];
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     last;
   logic [IDX_W-1:0]         tap_idx;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     va_ff, la_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, sum;
   logic signed [ACC_W:0]    rnd;
   logic                     out_valid_ff;
   logic signed [OUT_W-1:0]  out_data_ff;

   // load taps
   always_ff @(posedge clock) begin
      if (coef_wr.we && (32'(coef_wr.idx) < MAX_TAPS)) begin
         coef_ff[IDX_W'(coef_wr.idx)] <= coef_wr.value;
      end
   end

   // reversed tap for the current term
   always_comb begin
      last    = (cnt_ff == taps - CNT_W'(1));
      tap_idx = IDX_W'(taps - CNT_W'(1) - cnt_ff);
      prod_in = in_data * coef_ff[tap_idx];
      cnt_in  = cnt_ff;
      if (in_valid) begin
         cnt_in = last ? '0 : cnt_ff + CNT_W'(1);
      end
   end

   // accumulate and round the finished sum
   always_comb begin
      sum    = acc_ff + ACC_W'(prod_ff);
      rnd    = {sum[ACC_W-1], sum} + (ACC_W + 1)'(32768);
      acc_in = acc_ff;
      if (va_ff) begin
         acc_in = la_ff ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      la_ff   <= last;
      if (va_ff && la_ff) begin
         out_data_ff <= rnd[ACC_W:16];
      end
      if (reset) begin
         cnt_ff       <= '0;
         va_ff        <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         va_ff        <= in_valid;
         acc_ff       <= acc_in;
         out_valid_ff <= va_ff && la_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== design/sf3_checker.sv =====
// ----------------------------------------------------------------------------
// sf3_checker
// Port-level checks of the separable 3-D window filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "separable_3d_window_filter_assert.svh"

module sf3_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        csr_pready
);

   // a stalled result holds
   `SF3_CHECK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // a new result only appears after the input side was busy computing it
   `SF3_CHECK(a_rsp_after_busy, $rose(rsp_tvalid) |-> $past(!req_tready))

   // reset empties the output register
   `SF3_CHECK_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid)

   // register port never waits
   `SF3_CHECK_ALWAYS(a_pready, csr_pready)

endmodule

bind separable_3d_window_filter sf3_checker u_sf3_checker (.*);

`default_nettype wire
